// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL core of the matcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define MPDM_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger.
`define MPDM_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== hw/rtl/mpdm_pkg.sv =====
// Types and constants of the multi-pattern DFA matcher.
package mpdm_pkg;

  localparam int POS_W = 16;
  localparam int TAG_W = 16;
  localparam int LEN_W = 6;
  localparam int CNT_W = 16;

  // input word opcodes
  localparam logic [1:0] OP_SCAN     = 2'd0;
  localparam logic [1:0] OP_TRANS_WR = 2'd1;
  localparam logic [1:0] OP_INFO_WR  = 2'd2;

  // result kinds
  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // register index of match_limit (paddr[2])
  localparam logic REG_MATCH_LIMIT = 1'b0;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] position;
    logic [TAG_W-1:0] matched_id;
    logic [LEN_W-1:0] match_length;
    logic [CNT_W-1:0] match_total;
    logic             run_last;
  } result_t;

endpackage

// ===== hw/rtl/multi_pattern_dfa_matcher_core.sv =====
// Multi-pattern DFA matcher: transition and state-info memories, scan FSM, APB register.
//
//   channel   direction  handshake            word
//   in        sink       in_valid/in_ready    op, symbol, text_end, entry/info fields
//   out       source     out_valid/out_ready  kind, position, id, length, total, run_last
//   apb       slave      psel/penable/pready  match_limit at offset 0
//
// Table writes are taken from idle. A scan byte goes through a transition read and a
// state update, then visits each state on the output-link chain and ends in a flush
// state, where a held match and then the summary leave; with no walk only a text end
// reaches the flush state. The info memory port reads one chain state per cycle unless the walk stalls.
// rst is synchronous and clears control state only; memories hold garbage until loaded.
// A full output register stalls the chain walk and flush; the input waits for idle.
`include "assert_macros.svh"

module multi_pattern_dfa_matcher_core
  import mpdm_pkg::*;
#(
  parameter int NODE_COUNT      = 1024,
  parameter int ALPHABET        = 256,
  parameter int MAX_PATTERN_LEN = 63
) (
  input  logic              clk,
  input  logic              rst,
  // input words
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [7:0]        symbol,
  input  logic              text_end,
  input  logic [9:0]        entry_state,
  input  logic [9:0]        target_state,
  input  logic              accepting,
  input  logic [TAG_W-1:0]  pattern_tag,
  input  logic [LEN_W-1:0]  pattern_len,
  input  logic [9:0]        chain_link,
  // result words
  output logic              out_valid,
  input  logic              out_ready,
  output logic              kind,
  output logic [POS_W-1:0]  position,
  output logic [TAG_W-1:0]  matched_id,
  output logic [LEN_W-1:0]  match_length,
  output logic [CNT_W-1:0]  match_total,
  output logic              run_last,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int STW    = $clog2(NODE_COUNT);
  localparam int SYW    = $clog2(ALPHABET);
  localparam int TDEPTH = NODE_COUNT * (2 ** SYW);
  localparam int INFO_W = 1 + TAG_W + LEN_W + STW;
  localparam int VW     = $clog2(MAX_PATTERN_LEN + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TRANS,
    ST_CHAIN,
    ST_FLUSH
  } state_t;

  state_t state;

  // architectural state
  logic [STW-1:0]   cur_node;
  logic [POS_W-1:0] byte_pos;
  logic [CNT_W-1:0] rep_count;
  logic [CNT_W-1:0] match_limit;

  // per-scan context
  logic             scan_ok;
  logic             scan_end;
  logic [POS_W-1:0] scan_pos;
  logic [VW-1:0]    visits;

  // one match held back until we know whether it is the last result
  logic             pend_valid;
  logic [TAG_W-1:0] pend_id;
  logic [LEN_W-1:0] pend_len;

  result_t out_res;

  // memories (no reset, loaded by software)
  logic [STW-1:0]    trans_mem [TDEPTH];
  logic [INFO_W-1:0] info_mem  [NODE_COUNT];
  logic [STW-1:0]    trans_q;
  logic [INFO_W-1:0] info_q;

  logic              accept;
  logic              slot_free;
  logic              sym_ok;
  logic              entry_ok;
  logic [SYW-1:0]    sym_idx;
  logic [STW-1:0]    entry_idx;
  logic [STW-1:0]    tgt_clip;
  logic [STW-1:0]    link_clip;
  logic              trans_we;
  logic              trans_re;
  logic              info_we;
  logic              info_re;
  logic [STW-1:0]    info_raddr;
  logic [STW-1:0]    new_node;
  logic              e_acc;
  logic [TAG_W-1:0]  e_tag;
  logic [LEN_W-1:0]  e_len;
  logic [STW-1:0]    e_link;
  logic              hit;
  logic              chain_more;
  logic              chain_go;
  logic              cfg_wr;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // input decode; out-of-range writes are dropped, stored states clip to root
  assign sym_ok    = 32'(symbol) < ALPHABET;
  assign entry_ok  = 32'(entry_state) < NODE_COUNT;
  assign sym_idx   = SYW'(symbol);
  assign entry_idx = STW'(entry_state);
  assign tgt_clip  = (32'(target_state) < NODE_COUNT) ? STW'(target_state) : '0;
  assign link_clip = (32'(chain_link) < NODE_COUNT) ? STW'(chain_link) : '0;

  assign trans_we = accept && (op == OP_TRANS_WR) && entry_ok && sym_ok;
  assign trans_re = accept && (op == OP_SCAN) && sym_ok;
  assign info_we  = accept && (op == OP_INFO_WR) && entry_ok;

  // a byte outside the alphabet sends the scan to root
  assign new_node = scan_ok ? trans_q : '0;

  // unpack the state-info entry read for the current chain node
  assign e_acc  = info_q[INFO_W-1];
  assign e_tag  = info_q[INFO_W-2 -: TAG_W];
  assign e_len  = info_q[STW +: LEN_W];
  assign e_link = info_q[STW-1:0];

  assign hit        = e_acc && (rep_count < match_limit);
  assign chain_more = (e_link != '0) && (visits < VW'(MAX_PATTERN_LEN));
  // a new hit pushes the held match out, which needs the output register
  assign chain_go   = !(hit && pend_valid) || slot_free;

  always_comb begin
    info_re    = 1'b0;
    info_raddr = new_node;
    case (state)
      ST_TRANS: begin
        info_re    = (new_node != '0);
        info_raddr = new_node;
      end
      ST_CHAIN: begin
        info_re    = chain_go && chain_more;
        info_raddr = e_link;
      end
      default: begin
        info_re    = 1'b0;
        info_raddr = new_node;
      end
    endcase
  end

  // transition memory: one write or one read per cycle
  always_ff @(posedge clk) begin
    if (trans_we) begin
      trans_mem[{entry_idx, sym_idx}] <= tgt_clip;
    end
    if (trans_re) begin
      trans_q <= trans_mem[{cur_node, sym_idx}];
    end
  end

  // state-info memory: {accepting, tag, depth, link}
  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[entry_idx] <= {accepting, pattern_tag, pattern_len, link_clip};
    end
    if (info_re) begin
      info_q <= info_mem[info_raddr];
    end
  end

  // APB register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MATCH_LIMIT);
  assign prdata = (paddr[2] == REG_MATCH_LIMIT) ? {16'd0, match_limit} : 32'd0;

  // scan FSM, architectural state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cur_node    <= '0;
      byte_pos    <= '0;
      rep_count   <= '0;
      match_limit <= '1;
      out_valid   <= 1'b0;
      pend_valid  <= 1'b0;
      visits      <= '0;
      scan_ok     <= 1'b0;
      scan_end    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr) begin
        match_limit <= pwdata[CNT_W-1:0];
      end

      case (state)
        ST_IDLE: begin
          if (accept && (op == OP_SCAN)) begin
            scan_ok  <= sym_ok;
            scan_end <= text_end;
            scan_pos <= byte_pos;
            if (byte_pos != '1) begin
              byte_pos <= byte_pos + POS_W'(1);
            end
            state <= ST_TRANS;
          end
        end

        ST_TRANS: begin
          cur_node <= new_node;
          visits   <= VW'(1);
          if (new_node != '0) begin
            state <= ST_CHAIN;
          end else if (scan_end) begin
            state <= ST_FLUSH;
          end else begin
            state <= ST_IDLE;
          end
        end

        ST_CHAIN: begin
          if (chain_go) begin
            if (hit) begin
              rep_count  <= rep_count + CNT_W'(1);
              pend_valid <= 1'b1;
              pend_id    <= e_tag;
              pend_len   <= e_len;
              if (pend_valid) begin
                out_valid <= 1'b1;
                out_res   <= '{kind: KIND_MATCH, position: scan_pos, matched_id: pend_id,
                               match_length: pend_len, match_total: '0, run_last: 1'b0};
              end
            end
            if (chain_more) begin
              visits <= visits + VW'(1);
            end else begin
              state <= ST_FLUSH;
            end
          end
        end

        ST_FLUSH: begin
          if (pend_valid) begin
            if (slot_free) begin
              out_valid  <= 1'b1;
              out_res    <= '{kind: KIND_MATCH, position: scan_pos, matched_id: pend_id,
                              match_length: pend_len, match_total: '0,
                              run_last: !scan_end};
              pend_valid <= 1'b0;
              if (!scan_end) begin
                state <= ST_IDLE;
              end
            end
          end else if (scan_end) begin
            if (slot_free) begin
              out_valid <= 1'b1;
              out_res   <= '{kind: KIND_SUMMARY, position: scan_pos, matched_id: '0,
                             match_length: '0, match_total: rep_count, run_last: 1'b1};
              cur_node  <= '0;
              byte_pos  <= '0;
              rep_count <= '0;
              state     <= ST_IDLE;
            end
          end else begin
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign kind         = out_res.kind;
  assign position     = out_res.position;
  assign matched_id   = out_res.matched_id;
  assign match_length = out_res.match_length;
  assign match_total  = out_res.match_total;
  assign run_last     = out_res.run_last;

  // a held match never survives into the next input word
  `MPDM_ASSERT_NOW(a_no_pend_idle, state == ST_IDLE, !pend_valid,
    "held match left behind when returning to idle")
  // the chain walk is bounded
  `MPDM_ASSERT_NOW(a_visits_bound, state == ST_CHAIN,
    visits != '0 && 32'(visits) <= MAX_PATTERN_LEN, "chain visit count out of bounds")
  // a summary clears the per-text state
  `MPDM_ASSERT_NEXT(a_summary_reset,
    state == ST_FLUSH && !pend_valid && scan_end && slot_free,
    state == ST_IDLE && cur_node == '0 && byte_pos == '0 && rep_count == '0,
    "end of text did not clear node, position and count")

endmodule

// ===== tb/sv/multi_pattern_dfa_matcher_core_tb.sv =====
// Self-checking testbench for the multi-pattern DFA matcher core.
module multi_pattern_dfa_matcher_core_tb;
  import mpdm_pkg::*;

  // Longest output-link walk per scanned byte.
  localparam int CHAIN_MAX = 63;
  // Quiet cycles allowed before a register write and at the end: one byte
  // with a full chain walk and a full flush fits well inside this.
  localparam int DRAIN_CYCLES = 150;
  // Cycles without any accepted word before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES = 6;
  localparam int SCANS_PER_TEXT = 40;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] LIMIT_ADDR = {REG_MATCH_LIMIT, 2'b00};

  // One input word, all fields, whatever the op.
  typedef struct {
    logic [1:0]       op;
    logic [7:0]       symbol;
    logic             text_end;
    logic [9:0]       entry_state;
    logic [9:0]       target_state;
    logic             accepting;
    logic [TAG_W-1:0] pattern_tag;
    logic [LEN_W-1:0] pattern_len;
    logic [9:0]       chain_link;
  } dfa_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // input channel
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       op = OP_SCAN;
  logic [7:0]       symbol = '0;
  logic             text_end = 1'b0;
  logic [9:0]       entry_state = '0;
  logic [9:0]       target_state = '0;
  logic             accepting = 1'b0;
  logic [TAG_W-1:0] pattern_tag = '0;
  logic [LEN_W-1:0] pattern_len = '0;
  logic [9:0]       chain_link = '0;

  // result channel
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             kind;
  logic [POS_W-1:0] position;
  logic [TAG_W-1:0] matched_id;
  logic [LEN_W-1:0] match_length;
  logic [CNT_W-1:0] match_total;
  logic             run_last;

  // register port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Matcher state as the block should hold it.
  logic [9:0]       next_node [bit [17:0]];
  logic             node_accepting [1024];
  logic [TAG_W-1:0] node_tag [1024];
  logic [LEN_W-1:0] node_len [1024];
  logic [9:0]       node_link [1024];
  logic [9:0]       cur_node = '0;
  logic [POS_W-1:0] text_pos = '0;
  logic [CNT_W-1:0] text_reports = '0;
  logic [15:0]      limit_reg = 16'hFFFF;

  // Result words still to come, oldest first.
  result_t reports_due [$];

  // Current random DFA: its states (root first) and its byte columns.
  logic [9:0] dfa_states [$];
  logic [7:0] dfa_symbols [$];
  bit         state_taken [1024];

  bit calm = 1'b0;       // no idling on either side
  int mismatches = 0;
  int results_seen = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  multi_pattern_dfa_matcher_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .symbol       (symbol),
    .text_end     (text_end),
    .entry_state  (entry_state),
    .target_state (target_state),
    .accepting    (accepting),
    .pattern_tag  (pattern_tag),
    .pattern_len  (pattern_len),
    .chain_link   (chain_link),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .position     (position),
    .matched_id   (matched_id),
    .match_length (match_length),
    .match_total  (match_total),
    .run_last     (run_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch on %s: got %0d, want %0d (result %0d)", what, got, want, results_seen);
  endtask

  // Apply one accepted word to the matcher state, queue the results it causes.
  task automatic step_matcher(input dfa_word_t w);
    result_t    r;
    logic [9:0] walk;
    logic [POS_W-1:0] pos;
    int visits;
    int n;
    n = 0;
    case (w.op)
      OP_TRANS_WR: begin
        next_node[{w.entry_state, w.symbol}] = w.target_state;
      end
      OP_INFO_WR: begin
        node_accepting[w.entry_state] = w.accepting;
        node_tag[w.entry_state] = w.pattern_tag;
        node_len[w.entry_state] = w.pattern_len;
        node_link[w.entry_state] = w.chain_link;
      end
      OP_SCAN: begin
        pos = text_pos;
        cur_node = next_node[{cur_node, w.symbol}];
        // Walk the output links; the root ends the chain and is never reported.
        walk = cur_node;
        visits = 0;
        while (walk != 10'd0 && visits < CHAIN_MAX) begin
          visits++;
          if (node_accepting[walk] && text_reports < limit_reg) begin
            r = '0;
            r.kind = KIND_MATCH;
            r.position = pos;
            r.matched_id = node_tag[walk];
            r.match_length = node_len[walk];
            reports_due.push_back(r);
            text_reports++;
            n++;
          end
          walk = node_link[walk];
        end
        if (text_pos != 16'hFFFF) text_pos++;
        if (w.text_end) begin
          r = '0;
          r.kind = KIND_SUMMARY;
          r.position = pos;
          r.match_total = text_reports;
          reports_due.push_back(r);
          n++;
          cur_node = '0;
          text_pos = '0;
          text_reports = '0;
        end
      end
      default: begin
      end
    endcase
    if (n > 0) begin
      r = reports_due.pop_back();
      r.run_last = 1'b1;
      reports_due.push_back(r);
    end
  endtask

  function automatic dfa_word_t random_word();
    dfa_word_t w;
    w.op = 2'($urandom);
    w.symbol = 8'($urandom);
    w.text_end = 1'($urandom);
    w.entry_state = 10'($urandom);
    w.target_state = 10'($urandom);
    w.accepting = 1'($urandom);
    w.pattern_tag = 16'($urandom);
    w.pattern_len = 6'($urandom);
    w.chain_link = 10'($urandom);
    return w;
  endfunction

  function automatic dfa_word_t scan_word(input logic [7:0] sym, input logic last);
    dfa_word_t w;
    w = random_word();
    w.op = OP_SCAN;
    w.symbol = sym;
    w.text_end = last;
    return w;
  endfunction

  function automatic dfa_word_t trans_word(input logic [9:0] from, input logic [7:0] sym,
                                           input logic [9:0] to);
    dfa_word_t w;
    w = random_word();
    w.op = OP_TRANS_WR;
    w.entry_state = from;
    w.symbol = sym;
    w.target_state = to;
    return w;
  endfunction

  function automatic dfa_word_t info_word(input logic [9:0] st, input logic acc,
                                          input logic [TAG_W-1:0] tag,
                                          input logic [LEN_W-1:0] len, input logic [9:0] link);
    dfa_word_t w;
    w = random_word();
    w.op = OP_INFO_WR;
    w.entry_state = st;
    w.accepting = acc;
    w.pattern_tag = tag;
    w.pattern_len = len;
    w.chain_link = link;
    return w;
  endfunction

  function automatic logic [9:0] pick_state();
    return dfa_states[$urandom_range(0, dfa_states.size() - 1)];
  endfunction

  function automatic logic [7:0] pick_symbol();
    return dfa_symbols[$urandom_range(0, dfa_symbols.size() - 1)];
  endfunction

  // Offer one word, hold it until taken, then predict its results.
  task automatic send_word(input dfa_word_t w);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= w.op;
    symbol <= w.symbol;
    text_end <= w.text_end;
    entry_state <= w.entry_state;
    target_state <= w.target_state;
    accepting <= w.accepting;
    pattern_tag <= w.pattern_tag;
    pattern_len <= w.pattern_len;
    chain_link <= w.chain_link;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    step_matcher(w);
  endtask

  // match_limit is only written with the block idle: all results in, plus a
  // margin for a byte whose chain walk produced nothing.
  task automatic write_limit(input logic [15:0] value);
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LIMIT_ADDR;
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    limit_reg = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Tiny table over states 0, 1 and 1023 and bytes 0x00 and 0xFF:
  //   0 -00-> 1, 0 -FF-> 1023, 1 -00-> 1023, 1 -FF-> 0,
  //   1023 -00-> 1023, 1023 -FF-> 0.
  // State 1 ends a 63-byte pattern, 1023 links to itself (looping chain),
  // and the root is marked accepting but must stay silent.
  task automatic test_directed_table();
    send_word(trans_word(10'd0, 8'h00, 10'd1));
    send_word(trans_word(10'd0, 8'hFF, 10'd1023));
    send_word(trans_word(10'd1, 8'h00, 10'd1023));
    send_word(trans_word(10'd1, 8'hFF, 10'd0));
    send_word(trans_word(10'd1023, 8'h00, 10'd1023));
    send_word(trans_word(10'd1023, 8'hFF, 10'd0));
    send_word(info_word(10'd0, 1'b1, 16'h1234, 6'd5, 10'd1));
    send_word(info_word(10'd1, 1'b1, 16'hFFFF, 6'd63, 10'd0));
    send_word(info_word(10'd1023, 1'b1, 16'h0000, 6'd0, 10'd1023));
  endtask

  // Single match, a looping chain giving 63 matches in one byte, the summary
  // behind a full chain, and an unused op in mid-stream.
  task automatic test_chain_walk();
    dfa_word_t w;
    send_word(scan_word(8'h00, 1'b0));
    send_word(scan_word(8'h00, 1'b0));
    send_word(scan_word(8'hFF, 1'b1));
    w = random_word();
    w.op = OP_UNUSED;
    w.text_end = 1'b1;
    send_word(w);
    send_word(scan_word(8'hFF, 1'b0));
    send_word(scan_word(8'hFF, 1'b1));
  endtask

  // First-match behavior, then a limit of zero, then back to the reset value.
  task automatic test_match_limit();
    write_limit(16'd1);
    send_word(scan_word(8'h00, 1'b0));
    send_word(scan_word(8'h00, 1'b0));
    send_word(scan_word(8'hFF, 1'b1));
    write_limit(16'd0);
    send_word(scan_word(8'h00, 1'b0));
    send_word(scan_word(8'h00, 1'b0));
    send_word(scan_word(8'hFF, 1'b1));
    write_limit(16'hFFFF);
  endtask

  // One long text: the root loops on 0x00 for a while, then the looping
  // accepting state reports a full chain on every byte until the text ends.
  task automatic test_long_text();
    send_word(trans_word(10'd0, 8'h00, 10'd0));
    repeat (20) send_word(scan_word(8'h00, 1'b0));
    send_word(scan_word(8'hFF, 1'b0));
    repeat (10) send_word(scan_word(8'h00, 1'b0));
    send_word(scan_word(8'h00, 1'b1));
  endtask

  // Random DFAs over a handful of states and bytes; every text is closed so
  // that each phase starts at the root. Table rewrites and noise are mixed in.
  task automatic test_random_texts();
    int n_states;
    int n_syms;
    int pick;
    bit sym_taken [256];
    logic [9:0] s;
    logic [7:0] c;
    logic [15:0] lim;
    dfa_word_t w;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 5)
        0: lim = 16'hFFFF;
        1: lim = 16'($urandom_range(2, 8));
        2: lim = 16'd0;
        3: lim = 16'd1;
        default: lim = 16'($urandom);
      endcase
      write_limit(lim);
      // last phase runs with no idling at all
      if (p == NUM_PHASES - 1) calm = 1'b1;

      n_states = $urandom_range(4, 7);
      n_syms = $urandom_range(3, 5);
      foreach (state_taken[i]) state_taken[i] = 1'b0;
      foreach (sym_taken[i]) sym_taken[i] = 1'b0;
      dfa_states.delete();
      dfa_symbols.delete();
      dfa_states.push_back(10'd0);
      state_taken[0] = 1'b1;
      while (dfa_states.size() < n_states) begin
        s = 10'($urandom_range(1, 1023));
        if (!state_taken[s]) begin
          state_taken[s] = 1'b1;
          dfa_states.push_back(s);
        end
      end
      while (dfa_symbols.size() < n_syms) begin
        c = 8'($urandom);
        if (!sym_taken[c]) begin
          sym_taken[c] = 1'b1;
          dfa_symbols.push_back(c);
        end
      end

      // full rows and info for every state of the DFA
      foreach (dfa_states[i]) begin
        foreach (dfa_symbols[j]) send_word(trans_word(dfa_states[i], dfa_symbols[j], pick_state()));
      end
      foreach (dfa_states[i]) begin
        send_word(info_word(dfa_states[i], 1'($urandom), 16'($urandom),
                            6'($urandom), ($urandom_range(0, 1) == 0) ? 10'd0 : pick_state()));
      end

      for (int k = 0; k < SCANS_PER_TEXT; k++) begin
        pick = (k == SCANS_PER_TEXT - 1) ? 15 : $urandom_range(0, 15);
        case (pick)
          0: begin
            w = random_word();
            w.op = OP_UNUSED;
            send_word(w);
          end
          1: begin
            // write to a state the current scan never reaches
            w = random_word();
            w.op = ($urandom_range(0, 1) == 0) ? OP_TRANS_WR : OP_INFO_WR;
            while (state_taken[w.entry_state]) w.entry_state = 10'($urandom);
            send_word(w);
          end
          2: send_word(trans_word(pick_state(), pick_symbol(), pick_state()));
          3: begin
            send_word(info_word(pick_state(), 1'($urandom), 16'($urandom), 6'($urandom),
                                ($urandom_range(0, 1) == 0) ? 10'd0 : pick_state()));
          end
          default: begin
            send_word(scan_word(pick_symbol(),
                                (k == SCANS_PER_TEXT - 1) || ($urandom_range(0, 7) == 0)));
          end
        endcase
      end
    end
  endtask

  // Result side: random stall bursts unless calm.
  always @(posedge clk) begin
    if (rst || calm) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every accepted result word against the oldest one due.
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      got.kind = kind;
      got.position = position;
      got.matched_id = matched_id;
      got.match_length = match_length;
      got.match_total = match_total;
      got.run_last = run_last;
      if (reports_due.size() == 0) begin
        report_mismatch("result word with nothing due", 1, 0);
      end else begin
        want = reports_due.pop_front();
        if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
        if (got.position !== want.position)
          report_mismatch("position", got.position, want.position);
        if (got.matched_id !== want.matched_id)
          report_mismatch("matched_id", got.matched_id, want.matched_id);
        if (got.match_length !== want.match_length)
          report_mismatch("match_length", got.match_length, want.match_length);
        if (got.match_total !== want.match_total)
          report_mismatch("match_total", got.match_total, want.match_total);
        if (got.run_last !== want.run_last)
          report_mismatch("run_last", got.run_last, want.run_last);
      end
      results_seen++;
    end
  end

  // Hang detection: any accepted word on any port restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
        (psel && penable && pwrite && pready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_table();
    test_chain_walk();
    test_match_limit();
    test_long_text();
    test_random_texts();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
